>>> sv/i2c_master_bit_engine_assert.svh
// Assertion macros shared by the I2C master bit engine RTL.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define I2CM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/i2cm_pkg.sv
// Types and constants for the I2C master bit engine.
`timescale 1ns / 1ps

package i2cm_pkg;

  // Command codes of the action field
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_WRITE = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  // Configuration register indexes
  localparam logic CFG_HALF_BIT = 1'b0;
  localparam logic CFG_SETUP    = 1'b1;

  localparam int unsigned DLY_W  = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 4;

  localparam logic [DLY_W-1:0]  HALF_BIT_RST = 16'd150;
  localparam logic [DLY_W-1:0]  SETUP_RST    = 16'd250;
  localparam logic [CNT_W-1:0]  BITS_PER_BYTE = 4'd8;
  localparam int unsigned       MSB_IDX = BYTE_W - 1;

  // Bus phases
  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_ST1  = 5'd1,
    PH_ST2  = 5'd2,
    PH_SP1  = 5'd3,
    PH_SP2  = 5'd4,
    PH_SP3  = 5'd5,
    PH_W1   = 5'd6,
    PH_W2   = 5'd7,
    PH_W3   = 5'd8,
    PH_A1   = 5'd9,
    PH_A2   = 5'd10,
    PH_A3   = 5'd11,
    PH_R0   = 5'd12,
    PH_RH   = 5'd13,
    PH_R2   = 5'd14,
    PH_R3   = 5'd15,
    PH_K1   = 5'd16,
    PH_KH   = 5'd17,
    PH_K3   = 5'd18,
    PH_K4   = 5'd19
  } phase_t;

  // One input item
  typedef struct packed {
    logic [2:0]        action;
    logic [BYTE_W-1:0] write_data;
    logic              ack_read;
    logic              scl_line;
    logic              sda_line;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic              scl_drive_low;
    logic              sda_drive_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
    logic              nack;
  } res_t;

endpackage

>>> sv/i2cm_if.sv
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps

interface i2cm_in_if import i2cm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic [BYTE_W-1:0] write_data;
  logic              ack_read;
  logic              scl_line;
  logic              sda_line;

  modport source (output valid, action, write_data, ack_read, scl_line, sda_line,
                  input ready);
  modport sink (input valid, action, write_data, ack_read, scl_line, sda_line,
                output ready);
endinterface

interface i2cm_out_if import i2cm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              scl_drive_low;
  logic              sda_drive_low;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] read_data;
  logic              nack;

  modport source (output valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                  read_data, nack, input ready);
  modport sink (input valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                read_data, nack, output ready);
endinterface

>>> sv/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine.
// Usage:
//   in_ch carries one item per clock tick while ready is high: a command code
//   (none, start, stop, write byte, read byte), the byte to send, the ACK choice
//   for reads and the sampled SCL and SDA wires. Commands are ignored while busy.
//   out_ch returns one item per input item: the SCL/SDA pull-low drives, busy,
//   a one-tick done flag, the last read byte and the NACK of the last write.
//   cfg_we/cfg_index/cfg_data write the half-bit (index 0) and setup (index 1)
//   delay counts; write them only while the engine is idle.
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless a held result stalls; the state machine
//   steps once per item and the single result register decouples the two channels.
// Bus timing is counted in accepted items, not in clock cycles, so feed one
//   item per bus tick to keep the timing exact.
// Reset (rst_n low, synchronous): idle, both wires released, delays reset to
//   150 and 250 ticks, output channel empty.
// Stall: while out_ch.ready is low the held result stays and in_ch.ready
//   drops, so the engine pauses without losing a tick.
`timescale 1ns / 1ps

`include "i2c_master_bit_engine_assert.svh"

module i2c_master_bit_engine import i2cm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [DLY_W-1:0]  cfg_data,
  i2cm_in_if.sink           in_ch,
  i2cm_out_if.source        out_ch
);

  logic   in_ready;
  logic   step;
  cmd_t   cmd;
  res_t   res_nxt;
  res_t   res_q;
  phase_t phase;

  assign step     = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // Gather the input item
  always_comb begin
    cmd.action     = in_ch.action;
    cmd.write_data = in_ch.write_data;
    cmd.ack_read   = in_ch.ack_read;
    cmd.scl_line   = in_ch.scl_line;
    cmd.sda_line   = in_ch.sda_line;
  end

  i2cm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .cmd       (cmd),
    .res       (res_nxt),
    .phase     (phase)
  );

  i2cm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_in    (res_nxt),
    .out_ready (out_ch.ready),
    .in_ready  (in_ready),
    .out_valid (out_ch.valid),
    .res_out   (res_q)
  );

  // Drive the result channel
  assign out_ch.scl_drive_low = res_q.scl_drive_low;
  assign out_ch.sda_drive_low = res_q.sda_drive_low;
  assign out_ch.busy_res      = res_q.busy_res;
  assign out_ch.done_res      = res_q.done_res;
  assign out_ch.read_data     = res_q.read_data;
  assign out_ch.nack          = res_q.nack;

  // Checks
  `I2CM_ASSERT_NEXT(a_step_fills_out, clk, rst_n, step, out_ch.valid, "accepted item gave no result")
  `I2CM_ASSERT_NOW(a_stall_only_full, clk, rst_n, !in_ready, out_ch.valid && !out_ch.ready, "input stalled without a held result")
  `I2CM_ASSERT_NEXT(a_busy_matches, clk, rst_n, step, out_ch.busy_res == (phase != PH_IDLE), "busy flag disagrees with phase")
  `I2CM_ASSERT_NOW(a_done_not_busy, clk, rst_n, out_ch.valid && out_ch.done_res, !out_ch.busy_res, "done reported while busy")

endmodule

>>> sv/i2cm_core.sv
// Bus phase state machine: advances one tick per accepted item.
`timescale 1ns / 1ps

module i2cm_core import i2cm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [DLY_W-1:0]  cfg_data,
  input  logic              step,
  input  cmd_t              cmd,
  output res_t              res,
  output phase_t            phase
);

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   bit_r, bit_nxt;
  logic [DLY_W-1:0]   delay_r, delay_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic               scl_low_r, scl_low_nxt;
  logic               sda_low_r, sda_low_nxt;
  logic               ack_choice_r, ack_choice_nxt;
  logic               nack_r, nack_nxt;
  logic [BYTE_W-1:0]  rbyte_r, rbyte_nxt;
  logic [DLY_W-1:0]   half_bit_r;
  logic [DLY_W-1:0]   setup_r;
  logic               ovr;
  logic               done;
  logic [CNT_W-1:0]   bit_inc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_bit_r <= HALF_BIT_RST;
      setup_r    <= SETUP_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_HALF_BIT) begin
        half_bit_r <= cfg_data;
      end else begin
        setup_r <= cfg_data;
      end
    end
  end

  // State registers, advanced on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_r        <= '0;
      delay_r      <= '0;
      shift_r      <= '0;
      scl_low_r    <= 1'b0;
      sda_low_r    <= 1'b0;
      ack_choice_r <= 1'b0;
      nack_r       <= 1'b0;
      rbyte_r      <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bit_r        <= bit_nxt;
      delay_r      <= delay_nxt;
      shift_r      <= shift_nxt;
      scl_low_r    <= scl_low_nxt;
      sda_low_r    <= sda_low_nxt;
      ack_choice_r <= ack_choice_nxt;
      nack_r       <= nack_nxt;
      rbyte_r      <= rbyte_nxt;
    end
  end

  // Delay has run out once the count is one or zero
  assign ovr     = (delay_r <= 16'd1);
  assign bit_inc = bit_r + 4'd1;

  // Next state for one tick
  always_comb begin
    phase_nxt      = phase_r;
    bit_nxt        = bit_r;
    delay_nxt      = ovr ? delay_r : (delay_r - 16'd1);
    shift_nxt      = shift_r;
    scl_low_nxt    = scl_low_r;
    sda_low_nxt    = sda_low_r;
    ack_choice_nxt = ack_choice_r;
    nack_nxt       = nack_r;
    rbyte_nxt      = rbyte_r;
    done           = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        delay_nxt = delay_r;
        case (cmd.action)
          ACT_START: begin
            sda_low_nxt = 1'b0;
            scl_low_nxt = 1'b0;
            delay_nxt   = setup_r;
            phase_nxt   = PH_ST1;
          end
          ACT_STOP: begin
            sda_low_nxt = 1'b1;
            delay_nxt   = setup_r;
            phase_nxt   = PH_SP1;
          end
          ACT_WRITE: begin
            shift_nxt   = cmd.write_data;
            bit_nxt     = '0;
            sda_low_nxt = ~cmd.write_data[MSB_IDX];
            delay_nxt   = half_bit_r;
            phase_nxt   = PH_W1;
          end
          ACT_READ: begin
            ack_choice_nxt = cmd.ack_read;
            shift_nxt      = '0;
            bit_nxt        = '0;
            sda_low_nxt    = 1'b0;
            delay_nxt      = half_bit_r;
            phase_nxt      = PH_R0;
          end
          default: ;
        endcase
      end
      PH_ST1: if (ovr) begin
        sda_low_nxt = 1'b1;
        delay_nxt   = setup_r;
        phase_nxt   = PH_ST2;
      end
      PH_ST2: if (ovr) begin
        scl_low_nxt = 1'b1;
        done        = 1'b1;
        phase_nxt   = PH_IDLE;
      end
      PH_SP1: if (ovr) begin
        scl_low_nxt = 1'b0;
        delay_nxt   = setup_r;
        phase_nxt   = PH_SP2;
      end
      PH_SP2: if (ovr) begin
        sda_low_nxt = 1'b0;
        delay_nxt   = setup_r;
        phase_nxt   = PH_SP3;
      end
      PH_SP3: if (ovr) begin
        done      = 1'b1;
        phase_nxt = PH_IDLE;
      end
      PH_W1: if (ovr) begin
        scl_low_nxt = 1'b0;
        delay_nxt   = half_bit_r;
        phase_nxt   = PH_W2;
      end
      PH_W2: if (ovr && cmd.scl_line) begin
        scl_low_nxt = 1'b1;
        delay_nxt   = half_bit_r;
        phase_nxt   = PH_W3;
      end
      PH_W3: if (ovr) begin
        // shift out next bit, or hand SDA to the slave for ACK
        shift_nxt = {shift_r[BYTE_W-2:0], 1'b0};
        bit_nxt   = bit_inc;
        if (bit_inc < BITS_PER_BYTE) begin
          sda_low_nxt = ~shift_r[MSB_IDX-1];
          phase_nxt   = PH_W1;
        end else begin
          sda_low_nxt = 1'b0;
          phase_nxt   = PH_A1;
        end
        delay_nxt = half_bit_r;
      end
      PH_A1: if (ovr) begin
        scl_low_nxt = 1'b0;
        delay_nxt   = half_bit_r;
        phase_nxt   = PH_A2;
      end
      PH_A2: if (ovr && cmd.scl_line) begin
        delay_nxt = half_bit_r;
        phase_nxt = PH_A3;
      end
      PH_A3: if (ovr) begin
        nack_nxt    = cmd.sda_line;
        scl_low_nxt = 1'b1;
        done        = 1'b1;
        phase_nxt   = PH_IDLE;
      end
      PH_R0: if (ovr) begin
        scl_low_nxt = 1'b0;
        delay_nxt   = half_bit_r;
        phase_nxt   = PH_RH;
      end
      PH_RH: if (ovr && cmd.scl_line) begin
        shift_nxt = {shift_r[BYTE_W-2:0], cmd.sda_line};
        delay_nxt = half_bit_r;
        phase_nxt = PH_R2;
      end
      PH_R2: if (ovr) begin
        scl_low_nxt = 1'b1;
        delay_nxt   = half_bit_r;
        phase_nxt   = PH_R3;
      end
      PH_R3: if (ovr) begin
        bit_nxt = bit_inc;
        if (bit_inc < BITS_PER_BYTE) begin
          scl_low_nxt = 1'b0;
          phase_nxt   = PH_RH;
        end else begin
          sda_low_nxt = ack_choice_r;
          phase_nxt   = PH_K1;
        end
        delay_nxt = half_bit_r;
      end
      PH_K1: if (ovr) begin
        scl_low_nxt = 1'b0;
        delay_nxt   = half_bit_r;
        phase_nxt   = PH_KH;
      end
      PH_KH: if (ovr && cmd.scl_line) begin
        delay_nxt = half_bit_r;
        phase_nxt = PH_K3;
      end
      PH_K3: if (ovr) begin
        scl_low_nxt = 1'b1;
        delay_nxt   = half_bit_r;
        phase_nxt   = PH_K4;
      end
      PH_K4: if (ovr) begin
        sda_low_nxt = 1'b1;
        rbyte_nxt   = shift_r;
        done        = 1'b1;
        phase_nxt   = PH_IDLE;
      end
      default: begin
        delay_nxt = delay_r;
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Result of this tick: values after the update
  always_comb begin
    res.scl_drive_low = scl_low_nxt;
    res.sda_drive_low = sda_low_nxt;
    res.busy_res      = (phase_nxt != PH_IDLE);
    res.done_res      = done;
    res.read_data     = rbyte_nxt;
    res.nack          = nack_nxt;
  end

  assign phase = phase_r;

endmodule

>>> sv/i2cm_out_stage.sv
// Result register between the state machine and the output channel.
`timescale 1ns / 1ps

module i2cm_out_stage import i2cm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res_in,
  input  logic out_ready,
  output logic in_ready,
  output logic out_valid,
  output res_t res_out
);

  logic valid_r;
  res_t data_r;

  // Take a new item when no result is held or the held result leaves this cycle
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = data_r;

endmodule

>>> dv/i2cm_bit_checker.sv
// Checker for the I2C master bit engine: mirrors the engine tick by tick and compares results.
`timescale 1ns / 1ps

module i2cm_bit_checker import i2cm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [DLY_W-1:0] cfg_data,
  i2cm_in_if               in_ch,
  i2cm_out_if              out_ch,
  output int               fail_count,
  output int               pending,
  output int               checked
);

  // Mirrored engine state and delay settings
  phase_t            ph;
  logic [CNT_W-1:0]  nbits;
  logic [DLY_W-1:0]  dly;
  logic [BYTE_W-1:0] shreg;
  logic              scl_lo;
  logic              sda_lo;
  logic              ack_sel;
  logic              nack_q;
  logic [BYTE_W-1:0] rd_byte;
  logic [DLY_W-1:0]  half_q;
  logic [DLY_W-1:0]  setup_q;

  // Bus drives and status expected for items already accepted, oldest first
  res_t want_outputs[$];
  int   errs = 0;
  int   seen = 0;

  assign fail_count = errs;
  assign checked    = seen;

  // Counts the running delay down; true once it has run out (zero acts as one)
  function automatic logic timer_out();
    if (dly > 1) begin
      dly = dly - 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // One bus tick: advance the mirrored engine and return the line drives after it
  function automatic res_t advance_engine(cmd_t c);
    logic fin;
    logic tout;
    res_t r;
    fin = 1'b0;
    case (ph)
      PH_IDLE: begin
        case (c.action)
          ACT_START: begin
            sda_lo = 1'b0;
            scl_lo = 1'b0;
            dly    = setup_q;
            ph     = PH_ST1;
          end
          ACT_STOP: begin
            sda_lo = 1'b1;
            dly    = setup_q;
            ph     = PH_SP1;
          end
          ACT_WRITE: begin
            shreg  = c.write_data;
            nbits  = '0;
            sda_lo = ~c.write_data[MSB_IDX];
            dly    = half_q;
            ph     = PH_W1;
          end
          ACT_READ: begin
            ack_sel = c.ack_read;
            shreg   = '0;
            nbits   = '0;
            sda_lo  = 1'b0;
            dly     = half_q;
            ph      = PH_R0;
          end
          default: ;
        endcase
      end
      // start: release both, then SDA low, then SCL low
      PH_ST1: if (timer_out()) begin
        sda_lo = 1'b1;
        dly    = setup_q;
        ph     = PH_ST2;
      end
      PH_ST2: if (timer_out()) begin
        scl_lo = 1'b1;
        fin    = 1'b1;
        ph     = PH_IDLE;
      end
      // stop: timed only, no wait for SCL
      PH_SP1: if (timer_out()) begin
        scl_lo = 1'b0;
        dly    = setup_q;
        ph     = PH_SP2;
      end
      PH_SP2: if (timer_out()) begin
        sda_lo = 1'b0;
        dly    = setup_q;
        ph     = PH_SP3;
      end
      PH_SP3: if (timer_out()) begin
        fin = 1'b1;
        ph  = PH_IDLE;
      end
      // write data bits, MSB first
      PH_W1: if (timer_out()) begin
        scl_lo = 1'b0;
        dly    = half_q;
        ph     = PH_W2;
      end
      PH_W2: begin
        tout = timer_out();
        if (tout && c.scl_line) begin
          scl_lo = 1'b1;
          dly    = half_q;
          ph     = PH_W3;
        end
      end
      PH_W3: if (timer_out()) begin
        shreg = shreg << 1;
        nbits = nbits + 1'b1;
        if (nbits < BITS_PER_BYTE) begin
          sda_lo = ~shreg[MSB_IDX];
          ph     = PH_W1;
        end else begin
          sda_lo = 1'b0;
          ph     = PH_A1;
        end
        dly = half_q;
      end
      // slave acknowledge of a write
      PH_A1: if (timer_out()) begin
        scl_lo = 1'b0;
        dly    = half_q;
        ph     = PH_A2;
      end
      PH_A2: begin
        tout = timer_out();
        if (tout && c.scl_line) begin
          dly = half_q;
          ph  = PH_A3;
        end
      end
      PH_A3: if (timer_out()) begin
        nack_q = c.sda_line;
        scl_lo = 1'b1;
        fin    = 1'b1;
        ph     = PH_IDLE;
      end
      // read data bits, sampled while SCL is high
      PH_R0: if (timer_out()) begin
        scl_lo = 1'b0;
        dly    = half_q;
        ph     = PH_RH;
      end
      PH_RH: begin
        tout = timer_out();
        if (tout && c.scl_line) begin
          shreg = {shreg[BYTE_W-2:0], c.sda_line};
          dly   = half_q;
          ph    = PH_R2;
        end
      end
      PH_R2: if (timer_out()) begin
        scl_lo = 1'b1;
        dly    = half_q;
        ph     = PH_R3;
      end
      PH_R3: if (timer_out()) begin
        nbits = nbits + 1'b1;
        if (nbits < BITS_PER_BYTE) begin
          scl_lo = 1'b0;
          ph     = PH_RH;
        end else begin
          sda_lo = ack_sel;
          ph     = PH_K1;
        end
        dly = half_q;
      end
      // master ACK/NACK after a read
      PH_K1: if (timer_out()) begin
        scl_lo = 1'b0;
        dly    = half_q;
        ph     = PH_KH;
      end
      PH_KH: begin
        tout = timer_out();
        if (tout && c.scl_line) begin
          dly = half_q;
          ph  = PH_K3;
        end
      end
      PH_K3: if (timer_out()) begin
        scl_lo = 1'b1;
        dly    = half_q;
        ph     = PH_K4;
      end
      PH_K4: if (timer_out()) begin
        sda_lo  = 1'b1;
        rd_byte = shreg;
        fin     = 1'b1;
        ph      = PH_IDLE;
      end
      default: ph = PH_IDLE;
    endcase
    r.scl_drive_low = scl_lo;
    r.sda_drive_low = sda_lo;
    r.busy_res      = (ph != PH_IDLE);
    r.done_res      = fin;
    r.read_data     = rd_byte;
    r.nack          = nack_q;
    return r;
  endfunction

  // Watch config writes, check results, predict accepted items
  always @(posedge clk) begin
    cmd_t c;
    res_t got;
    res_t exp_r;
    if (!rst_n) begin
      ph      = PH_IDLE;
      nbits   = '0;
      dly     = '0;
      shreg   = '0;
      scl_lo  = 1'b0;
      sda_lo  = 1'b0;
      ack_sel = 1'b0;
      nack_q  = 1'b0;
      rd_byte = '0;
      half_q  = HALF_BIT_RST;
      setup_q = SETUP_RST;
      want_outputs.delete();
    end else begin
      // result side first: its expectation came from an earlier item
      if (out_ch.valid && out_ch.ready) begin
        got.scl_drive_low = out_ch.scl_drive_low;
        got.sda_drive_low = out_ch.sda_drive_low;
        got.busy_res      = out_ch.busy_res;
        got.done_res      = out_ch.done_res;
        got.read_data     = out_ch.read_data;
        got.nack          = out_ch.nack;
        seen++;
        if (want_outputs.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: result item with nothing expected: scl=%0b sda=%0b busy=%0b",
                     $realtime, got.scl_drive_low, got.sda_drive_low, got.busy_res);
        end else begin
          exp_r = want_outputs.pop_front();
          if (got.scl_drive_low !== exp_r.scl_drive_low ||
              got.sda_drive_low !== exp_r.sda_drive_low ||
              got.busy_res !== exp_r.busy_res || got.done_res !== exp_r.done_res ||
              got.read_data !== exp_r.read_data || got.nack !== exp_r.nack) begin
            errs++;
            if (errs <= 10)
              $display({"%0t: mismatch exp scl=%0b sda=%0b busy=%0b done=%0b rd=%02h",
                        " nack=%0b | got scl=%0b sda=%0b busy=%0b done=%0b rd=%02h nack=%0b"},
                       $realtime, exp_r.scl_drive_low, exp_r.sda_drive_low,
                       exp_r.busy_res, exp_r.done_res, exp_r.read_data, exp_r.nack,
                       got.scl_drive_low, got.sda_drive_low, got.busy_res,
                       got.done_res, got.read_data, got.nack);
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        c.action     = in_ch.action;
        c.write_data = in_ch.write_data;
        c.ack_read   = in_ch.ack_read;
        c.scl_line   = in_ch.scl_line;
        c.sda_line   = in_ch.sda_line;
        want_outputs.push_back(advance_engine(c));
      end

      // a register write takes effect for items after this edge
      if (cfg_we) begin
        if (cfg_index == CFG_HALF_BIT) half_q = cfg_data;
        else setup_q = cfg_data;
      end
    end
    pending <= want_outputs.size();
  end

endmodule

>>> dv/i2c_master_bit_engine_tb.sv
// Testbench top for the I2C master bit engine: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module i2c_master_bit_engine_tb;
  import i2cm_pkg::*;

  // Action codes the engine treats as none
  localparam int ACT_UNUSED_LO = 5;
  localparam int ACT_UNUSED_HI = 7;

  // How the SDA wire is driven by the bus model during a command
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  localparam int RANDOM_TICKS = 250;
  localparam int LONG_HOLD    = 400;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [DLY_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;

  i2cm_in_if  in_ch();
  i2cm_out_if out_ch();

  i2c_master_bit_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  i2cm_bit_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #1 clk = ~clk;

  bit calm = 1'b1;
  bit long_hold_req = 1'b0;
  int done_seen = 0;
  int ticks_sent = 0;
  int n_start = 0;
  int n_stop = 0;
  int n_write = 0;
  int n_read = 0;
  int n_settings = 0;

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic pick_sda(int mode);
    if (mode == SDA_RAND) return 1'($urandom_range(0, 1));
    return (mode == SDA_HIGH);
  endfunction

  // Filler action: mostly none, sometimes an unused code
  function automatic logic [2:0] filler_act();
    if ($urandom_range(0, 7) == 0) return 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    return ACT_NONE;
  endfunction

  // Count finished commands as they leave the engine
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready && out_ch.done_res) done_seen <= done_seen + 1;
  end

  // Result side: random stalls plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        stall_left = LONG_HOLD - 1;
        long_hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = gap_len() - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one bus tick and wait until it is taken
  task automatic push_tick(logic [2:0] act, logic [BYTE_W-1:0] wd, logic ack,
                           logic scl, logic sda);
    bit took;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.write_data <= wd;
    in_ch.ack_read   <= ack;
    in_ch.scl_line   <= scl;
    in_ch.sda_line   <= sda;
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    ticks_sent++;
  endtask

  // Issue a command from idle, then tick the bus until its done comes back.
  // The tick right after the command carries busy_act, which must be ignored.
  task automatic run_cmd(logic [2:0] act, logic [BYTE_W-1:0] wd, logic ack,
                         logic [2:0] busy_act, int sda_mode, int scl_low_pct);
    int d0;
    d0 = done_seen;
    push_tick(act, wd, ack, 1'b1, 1'($urandom_range(0, 1)));
    push_tick(busy_act, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1, pick_sda(sda_mode));
    while (done_seen == d0)
      push_tick(filler_act(), 8'($urandom), 1'($urandom_range(0, 1)),
                $urandom_range(0, 99) >= scl_low_pct, pick_sda(sda_mode));
    case (act)
      ACT_START: n_start++;
      ACT_STOP:  n_stop++;
      ACT_WRITE: n_write++;
      ACT_READ:  n_read++;
      default: ;
    endcase
  endtask

  // Write both delay registers once the engine has drained
  task automatic load_delays(logic [DLY_W-1:0] hb, logic [DLY_W-1:0] st);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HALF_BIT;
    cfg_data  <= hb;
    @(posedge clk);
    cfg_index <= CFG_SETUP;
    cfg_data  <= st;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  // One random transfer: mostly well formed, sometimes a stray command
  task automatic random_transfer();
    int pct;
    pct = $urandom_range(0, 30);
    repeat ($urandom_range(0, 2))
      push_tick(filler_act(), 8'($urandom), 1'($urandom_range(0, 1)), 1'b1, 1'b1);
    if ($urandom_range(0, 9) == 0) begin
      run_cmd(3'($urandom_range(ACT_START, ACT_READ)), 8'($urandom),
              1'($urandom_range(0, 1)), 3'($urandom), SDA_RAND, pct);
    end else begin
      run_cmd(ACT_START, 8'($urandom), 1'b0, 3'($urandom), SDA_RAND, pct);
      repeat ($urandom_range(1, 3))
        run_cmd(ACT_WRITE, 8'($urandom), 1'b0, 3'($urandom), SDA_RAND, pct);
      if ($urandom_range(0, 2) == 0)
        run_cmd(ACT_START, 8'($urandom), 1'b0, 3'($urandom), SDA_RAND, pct);
      repeat ($urandom_range(0, 2))
        run_cmd(ACT_READ, 8'($urandom), 1'($urandom_range(0, 1)), 3'($urandom),
                SDA_RAND, pct);
      if ($urandom_range(0, 7) != 0)
        run_cmd(ACT_STOP, 8'($urandom), 1'b0, 3'($urandom), SDA_RAND, pct);
    end
  endtask

  // Stimulus and verdict
  initial begin
    logic [DLY_W-1:0] hb_set[5];
    logic [DLY_W-1:0] st_set[5];
    int base;
    int wait_cnt;
    hb_set = '{16'd1, 16'd0, 16'd2, 16'd1, 16'd1};
    st_set = '{16'd1, 16'd2, 16'd1, 16'd0, 16'd3};

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_HALF_BIT;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_NONE;
    in_ch.write_data <= '0;
    in_ch.ack_read   <= 1'b0;
    in_ch.scl_line   <= 1'b1;
    in_ch.sda_line   <= 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset setup delay, one start
    run_cmd(ACT_START, 8'h00, 1'b0, ACT_WRITE, SDA_RAND, 0);

    // Directed: shortest delays, ACK and NACK, repeated start, stretching
    load_delays(16'd1, 16'd1);
    calm = 1'b0;
    run_cmd(ACT_START, 8'h5A, 1'b0, ACT_STOP, SDA_RAND, 10);
    run_cmd(ACT_WRITE, 8'h00, 1'b0, ACT_WRITE, SDA_LOW, 30);
    run_cmd(ACT_WRITE, 8'hA5, 1'b1, ACT_START, SDA_HIGH, 10);
    run_cmd(ACT_START, 8'hFF, 1'b1, ACT_READ, SDA_RAND, 10);
    run_cmd(ACT_READ, 8'h00, 1'b1, ACT_READ, SDA_HIGH, 10);
    run_cmd(ACT_READ, 8'hFF, 1'b0, ACT_STOP, SDA_LOW, 10);
    run_cmd(ACT_READ, 8'($urandom), 1'b1, ACT_WRITE, SDA_RAND, 50);
    run_cmd(ACT_STOP, 8'h00, 1'b0, ACT_READ, SDA_RAND, 10);
    for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
      push_tick(3'(a), 8'($urandom), 1'b1, 1'b0, 1'b0);
    push_tick(ACT_NONE, 8'hFF, 1'b1, 1'b1, 1'b1);

    // Directed: zero delay registers act as one tick
    load_delays(16'd0, 16'd0);
    run_cmd(ACT_START, 8'h00, 1'b0, ACT_START, SDA_RAND, 10);
    run_cmd(ACT_WRITE, 8'h81, 1'b0, ACT_STOP, SDA_RAND, 10);
    run_cmd(ACT_READ, 8'h7E, 1'b1, ACT_WRITE, SDA_RAND, 10);
    run_cmd(ACT_STOP, 8'h00, 1'b0, ACT_READ, SDA_RAND, 10);

    // Random transfers over several delay settings
    for (int s = 0; s < 5; s++) begin
      load_delays(hb_set[s], st_set[s]);
      calm = ($urandom_range(0, 3) == 0);
      if (s == 1) begin
        calm = 1'b0;
        long_hold_req = 1'b1;
      end
      base = ticks_sent;
      while (ticks_sent - base < RANDOM_TICKS / 5) random_transfer();
    end

    // Drain
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 5000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (5) @(posedge clk);

    $display("Covered %0d bus ticks, %0d results checked, %0d delay settings incl. zero.",
             ticks_sent, checked, n_settings);
    $display("Commands: %0d start, %0d write, %0d read, %0d stop; stretching and a long hold-off.",
             n_start, n_write, n_read, n_stop);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
